// File: sv/bel_pkg.sv
`default_nettype none

package bel_pkg;

    // Token kinds as they appear on the output.
    localparam logic [3:0] TK_END   = 4'd0;
    localparam logic [3:0] TK_ZERO  = 4'd1;
    localparam logic [3:0] TK_ONE   = 4'd2;
    localparam logic [3:0] TK_NUM   = 4'd3;
    localparam logic [3:0] TK_LP    = 4'd4;
    localparam logic [3:0] TK_RP    = 4'd5;
    localparam logic [3:0] TK_AND   = 4'd6;
    localparam logic [3:0] TK_OR    = 4'd7;
    localparam logic [3:0] TK_XOR   = 4'd8;
    localparam logic [3:0] TK_NOT   = 4'd9;
    localparam logic [3:0] TK_ERROR = 4'd10;

    // Lexer phases.
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_NUM   = 3'd1;
    localparam logic [2:0] PH_Z     = 3'd2;
    localparam logic [2:0] PH_ZE    = 3'd3;
    localparam logic [2:0] PH_ZER   = 3'd4;
    localparam logic [2:0] PH_O     = 3'd5;
    localparam logic [2:0] PH_ON    = 3'd6;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG9   = 8'h39;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_N_LO   = 8'h6E;
    localparam logic [7:0] CH_N_UP   = 8'h4E;
    localparam logic [7:0] CH_O_LO   = 8'h6F;
    localparam logic [7:0] CH_O_UP   = 8'h4F;
    localparam logic [7:0] CH_R_LO   = 8'h72;
    localparam logic [7:0] CH_R_UP   = 8'h52;
    localparam logic [7:0] CH_Z_LO   = 8'h7A;
    localparam logic [7:0] CH_Z_UP   = 8'h5A;

    localparam int LIT_W   = 32;
    localparam int TDATA_W = 40;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [3:0]       kind;
        logic [LIT_W-1:0] lit;
        logic             last;
    } token_t;

endpackage

`default_nettype wire

// File: sv/boolean_expression_lexer.sv
// Boolean expression lexer.
// Input stream (s_*): one word per character. s_tdata carries the character
// byte, s_tuser is 1 for the end-of-input mark (the byte is then ignored).
// Output stream (m_*): one word per token. m_tdata holds the token kind in
// bits 3:0 and the literal value in bits 35:4; m_tlast marks the final token
// caused by one input word.
// Each accepted character updates the lexer state in the same cycle and
// pushes zero, one or two tokens into a four-entry registered result queue,
// so a token reaches m_tvalid in the cycle after acceptance at the earliest.
// A character is taken every cycle while at least two queue entries are free,
// so the block runs at one character per cycle; a character that yields two
// tokens (a number closed by a symbol, NUL or end of input) sends them one
// after another, which the output port bounds. When the receiver stalls, the
// queue fills and s_tready drops once fewer than two entries are free.
// Reset puts the lexer in its start state and empties the queue.
`default_nettype none

module boolean_expression_lexer #(
    parameter int ID_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,  // char_code
    input  wire logic                        s_tuser,  // action
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [bel_pkg::TDATA_W-1:0]      m_tdata,  // token_kind, literal_id, zero pad
    output logic                             m_tlast
);

    import bel_pkg::*;

    localparam int SUM_W = ID_WIDTH + 4;

    logic [2:0]          phase_reg;
    logic [2:0]          phase_next;
    logic [ID_WIDTH-1:0] acc_reg;
    logic [ID_WIDTH-1:0] acc_next;

    token_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;

    logic                s_fire;
    logic                m_fire;
    logic [7:0]          c;
    logic [3:0]          sym;
    logic                sym_hit;
    logic                is_blank;
    logic                is_digit;
    logic [3:0]          digit;
    logic [SUM_W-1:0]    sum;
    logic                overflow;
    logic [1:0]          n_tok;
    logic [3:0]          kind0;
    logic [LIT_W-1:0]    lit0;
    logic [3:0]          kind1;
    token_t              ent0;
    token_t              ent1;
    token_t              head;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign c      = s_tdata;

    always_comb
    begin
        unique case (c)
            CH_NUL:               sym = TK_END;
            CH_STAR, CH_AMP:      sym = TK_AND;
            CH_PLUS, CH_PIPE:     sym = TK_OR;
            CH_CARET:             sym = TK_XOR;
            CH_TILDE, CH_BANG:    sym = TK_NOT;
            CH_LPAREN:            sym = TK_LP;
            CH_RPAREN:            sym = TK_RP;
            default:              sym = TK_ERROR;
        endcase
    end

    assign sym_hit  = (sym != TK_ERROR);
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
    assign is_digit = (c >= CH_DIG0) && (c <= CH_DIG9);
    assign digit    = 4'(c - CH_DIG0);

    // acc * 10 + digit; anything above the accumulator width is overflow.
    assign sum      = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + SUM_W'(digit);
    assign overflow = |sum[SUM_W-1:ID_WIDTH];

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        n_tok      = 2'd0;
        kind0      = TK_END;
        lit0       = '0;
        kind1      = TK_END;
        if (s_tuser)
        begin
            n_tok = 2'd1;
            if (phase_reg == PH_NUM)
            begin
                n_tok = 2'd2;
                kind0 = TK_NUM;
                lit0  = LIT_W'(acc_reg);
            end
            else if (phase_reg != PH_START)
            begin
                kind0 = TK_ERROR;
            end
            phase_next = PH_START;
            acc_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (sym_hit)
                    begin
                        n_tok = 2'd1;
                        kind0 = sym;
                    end
                    else if (is_digit)
                    begin
                        acc_next   = ID_WIDTH'(digit);
                        phase_next = PH_NUM;
                    end
                    else if ((c == CH_Z_LO) || (c == CH_Z_UP))
                    begin
                        phase_next = PH_Z;
                    end
                    else if ((c == CH_O_LO) || (c == CH_O_UP))
                    begin
                        phase_next = PH_O;
                    end
                    else if (!is_blank)
                    begin
                        n_tok = 2'd1;
                        kind0 = TK_ERROR;
                    end
                end
                PH_NUM:
                begin
                    if (is_digit && !overflow)
                    begin
                        acc_next = sum[ID_WIDTH-1:0];
                    end
                    else
                    begin
                        phase_next = PH_START;
                        acc_next   = '0;
                        n_tok      = 2'd1;
                        if (is_digit)
                        begin
                            kind0 = TK_ERROR;
                        end
                        else if (sym_hit || is_blank)
                        begin
                            kind0 = TK_NUM;
                            lit0  = LIT_W'(acc_reg);
                            if (sym_hit)
                            begin
                                n_tok = 2'd2;
                                kind1 = sym;
                            end
                        end
                        else
                        begin
                            kind0 = TK_ERROR;
                        end
                    end
                end
                PH_Z, PH_ZE, PH_O:
                begin
                    if ((phase_reg == PH_Z) && ((c == CH_E_LO) || (c == CH_E_UP)))
                    begin
                        phase_next = PH_ZE;
                    end
                    else if ((phase_reg == PH_ZE) && ((c == CH_R_LO) || (c == CH_R_UP)))
                    begin
                        phase_next = PH_ZER;
                    end
                    else if ((phase_reg == PH_O) && ((c == CH_N_LO) || (c == CH_N_UP)))
                    begin
                        phase_next = PH_ON;
                    end
                    else
                    begin
                        phase_next = PH_START;
                        n_tok      = 2'd1;
                        kind0      = TK_ERROR;
                    end
                end
                PH_ZER, PH_ON:
                begin
                    phase_next = PH_START;
                    n_tok      = 2'd1;
                    if ((phase_reg == PH_ZER) && ((c == CH_O_LO) || (c == CH_O_UP)))
                    begin
                        kind0 = TK_ZERO;
                    end
                    else if ((phase_reg == PH_ON) && ((c == CH_E_LO) || (c == CH_E_UP)))
                    begin
                        kind0 = TK_ONE;
                    end
                    else
                    begin
                        kind0 = TK_ERROR;
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                    acc_next   = '0;
                    n_tok      = 2'd1;
                    kind0      = TK_ERROR;
                end
            endcase
        end
    end

    always_comb
    begin
        ent0.kind = kind0;
        ent0.lit  = lit0;
        ent0.last = (n_tok == 2'd1);
        ent1.kind = kind1;
        ent1.lit  = '0;
        ent1.last = 1'b1;
    end

    // Two free entries guarantee room for the largest token burst.
    assign s_tready = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        rd_ptr_next = rd_ptr_reg;
        if (s_fire)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(n_tok);
            cnt_next    = cnt_next + QCNT_W'(n_tok);
        end
        if (m_fire)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
            cnt_next    = cnt_next - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            acc_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (s_fire)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && (n_tok != 2'd0))
        begin
            queue_mem[wr_ptr_reg] <= ent0;
        end
        if (s_fire && (n_tok == 2'd2))
        begin
            queue_mem[wr_ptr_reg + QPTR_W'(1)] <= ent1;
        end
    end

    assign head     = queue_mem[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {(TDATA_W - LIT_W - 4)'(0), head.lit, head.kind};
    assign m_tlast  = head.last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue count above depth");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ((m_tdata[3:0] == TK_END) || (m_tdata[3:0] == TK_ERROR))) |-> m_tlast)
        else $error("END or ERROR token not marked last");

    a_lit_only_num: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[3:0] != TK_NUM)) |-> (m_tdata[35:4] == '0))
        else $error("literal set on a non-number token");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_tuser) |=> (phase_reg == PH_START))
        else $error("lexer not back at start after end of input");
`endif

endmodule

`default_nettype wire
